>>> sv/spuf_pkg.sv
package spuf_pkg;

	localparam int CNT_W  = 17;
	localparam int HLEN_W = 16;

	localparam logic [CNT_W-1:0] COUNT_MAX    = 17'h1_FFFF;
	localparam logic [CNT_W-1:0] POS_VERSION  = 17'd0;
	localparam logic [CNT_W-1:0] POS_SIG_TYPE = 17'd1;
	localparam logic [CNT_W-1:0] POS_HLEN_HI  = 17'd4;
	localparam logic [CNT_W-1:0] POS_HLEN_LO  = 17'd5;
	localparam logic [CNT_W:0]   HEADER_BYTES = 18'd6;

	localparam logic [7:0] VERSION_4        = 8'd4;
	localparam logic [7:0] VERSION_5        = 8'd5;
	localparam logic [7:0] SIG_TYPE_MIN     = 8'h10;
	localparam logic [7:0] SIG_TYPE_MAX     = 8'h13;
	localparam logic [7:0] LEN_TWO_BYTE     = 8'd192;
	localparam logic [7:0] LEN_FIVE_BYTE    = 8'd255;
	localparam logic [7:0] TYPE_MASK        = 8'h7f;
	localparam logic [7:0] PRIMARY_UID_TYPE = 8'd25;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LEN1,
		PH_LEN2,
		PH_LEN4,
		PH_TYPE,
		PH_VALUE,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic is_primary;
		logic header_ok;
	} out_word_t;

endpackage

>>> sv/sig_primary_uid_flag_scan.sv
// Primary user id flag scan over one signature packet.
// Input channel item/item_valid/item_ready carries one packet byte per word,
// with last_byte set on the final byte of the packet.
// Output channel result/result_valid/result_ready carries one word per
// packet: header_ok (version, signature type and hashed length checks) and
// is_primary (header_ok set and a primary user id subpacket with a non-zero value was found).
// Words without last_byte produce no result.
// Throughput: one byte per cycle unless a last byte waits for a pending result;
// each byte updates the parser state at the clock edge where it leaves the
// input register, and at that edge a last byte also loads the result register.
// Reset clears the parser to the header phase and empties both registers;
// after each last byte the parser returns to that state on its own.
// While result_ready is low, bytes that carry no result keep flowing; a last
// byte waits in the input register until the pending result is taken, and
// item_ready drops behind it.
module sig_primary_uid_flag_scan
	import spuf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  item,
	input  logic      item_valid,
	output logic      item_ready,
	output out_word_t result,
	output logic      result_valid,
	input  logic      result_ready
);

	in_word_t  item_s1;
	logic      valid_s1;
	logic      advance;
	out_word_t core_result;
	out_word_t result_q;
	logic      result_valid_q;

	assign advance = valid_s1
		&& (!item_s1.last_byte || !result_valid_q || result_ready);
	assign item_ready   = !valid_s1 || advance;
	assign result       = result_q;
	assign result_valid = result_valid_q;

	spuf_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.word   (item_s1),
		.result (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && item_s1.last_byte) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_byte) begin
			result_q <= core_result;
		end
	end

endmodule

>>> sv/spuf_core.sv
module spuf_core
	import spuf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_word_t  word,
	output out_word_t result
);

	logic [CNT_W-1:0]  byte_count_q, byte_count_d;
	logic              header_valid_q, header_valid_d;
	logic [HLEN_W-1:0] hashed_length_q, hashed_length_d;
	phase_t            phase_q, phase_d;
	logic [HLEN_W-1:0] area_offset_q, area_offset_d;
	logic [HLEN_W-1:0] sub_remaining_q, sub_remaining_d;
	logic              len_big_q, len_big_d;
	logic [1:0]        length_shift_q, length_shift_d;
	logic              type_matched_q, type_matched_d;
	logic              found_q, found_d;
	logic              stopped_q, stopped_d;

	logic [7:0]        b;
	logic [HLEN_W-1:0] off_inc;
	logic [HLEN_W-1:0] limit;
	logic [HLEN_W-1:0] sr_dec;
	logic [HLEN_W-1:0] plen;
	logic              plen_big;
	logic              do_check;
	logic [7:0]        b_minus;
	logic [CNT_W:0]    total;
	logic              ok;

	always_comb begin
		b        = word.data_byte;
		off_inc  = area_offset_q + 16'd1;
		limit    = hashed_length_q - off_inc;
		sr_dec   = sub_remaining_q - 16'd1;
		b_minus  = b - LEN_TWO_BYTE;
		plen     = '0;
		plen_big = 1'b0;
		do_check = 1'b0;

		byte_count_d    = byte_count_q;
		header_valid_d  = header_valid_q;
		hashed_length_d = hashed_length_q;
		phase_d         = phase_q;
		area_offset_d   = area_offset_q;
		sub_remaining_d = sub_remaining_q;
		len_big_d       = len_big_q;
		length_shift_d  = length_shift_q;
		type_matched_d  = type_matched_q;
		found_d         = found_q;
		stopped_d       = stopped_q;

		if (phase_q == PH_HEADER) begin
			unique case (byte_count_q)
				POS_VERSION: begin
					header_valid_d = (b == VERSION_4) || (b == VERSION_5);
				end
				POS_SIG_TYPE: begin
					header_valid_d = header_valid_q && (b >= SIG_TYPE_MIN)
						&& (b <= SIG_TYPE_MAX);
				end
				POS_HLEN_HI: begin
					hashed_length_d = {b, 8'h00};
				end
				POS_HLEN_LO: begin
					hashed_length_d = {hashed_length_q[15:8], b};
					phase_d         = PH_LEN1;
				end
				default: begin
				end
			endcase
		end else if (!stopped_q) begin
			unique case (phase_q)
				PH_LEN1: begin
					if ({1'b0, area_offset_q} + 17'd2 >= {1'b0, hashed_length_q}) begin
						stopped_d = 1'b1;
					end else begin
						area_offset_d = off_inc;
						if (b < LEN_TWO_BYTE) begin
							plen     = {8'h00, b};
							do_check = 1'b1;
						end else if (b < LEN_FIVE_BYTE) begin
							sub_remaining_d = {b_minus, 8'h00};
							phase_d         = PH_LEN2;
						end else if ({1'b0, off_inc} + 17'd4 > {1'b0, hashed_length_q}) begin
							stopped_d = 1'b1;
						end else begin
							sub_remaining_d = '0;
							len_big_d       = 1'b0;
							length_shift_d  = '0;
							phase_d         = PH_LEN4;
						end
					end
				end
				PH_LEN2: begin
					area_offset_d = off_inc;
					plen          = sub_remaining_q + {8'h00, b} + {8'h00, LEN_TWO_BYTE};
					do_check      = 1'b1;
				end
				PH_LEN4: begin
					area_offset_d   = off_inc;
					len_big_d       = len_big_q || (sub_remaining_q[15:8] != 8'h00);
					sub_remaining_d = {sub_remaining_q[7:0], b};
					length_shift_d  = length_shift_q + 2'd1;
					if (length_shift_q == 2'd3) begin
						plen     = {sub_remaining_q[7:0], b};
						plen_big = len_big_d;
						do_check = 1'b1;
					end
				end
				PH_TYPE: begin
					area_offset_d   = off_inc;
					type_matched_d  = (b & TYPE_MASK) == PRIMARY_UID_TYPE;
					sub_remaining_d = sr_dec;
					phase_d         = (sr_dec == '0) ? PH_LEN1 : PH_VALUE;
				end
				PH_VALUE: begin
					area_offset_d = off_inc;
					if (type_matched_q && (b != 8'h00)) begin
						found_d   = 1'b1;
						stopped_d = 1'b1;
					end else begin
						sub_remaining_d = sr_dec;
						phase_d         = (sr_dec == '0) ? PH_LEN1 : PH_SKIP;
					end
				end
				PH_SKIP: begin
					area_offset_d   = off_inc;
					sub_remaining_d = sr_dec;
					if (sr_dec == '0) begin
						phase_d = PH_LEN1;
					end
				end
				default: begin
				end
			endcase

			if (do_check) begin
				if (plen_big || (plen == '0) || (plen > limit)) begin
					stopped_d = 1'b1;
				end else begin
					sub_remaining_d = plen;
					phase_d         = PH_TYPE;
				end
			end
		end

		total = {1'b0, byte_count_q} + 18'd1;
		if (byte_count_q != COUNT_MAX) begin
			byte_count_d = byte_count_q + 17'd1;
		end

		ok = (total >= HEADER_BYTES) && header_valid_d
			&& ({2'b00, hashed_length_d} + HEADER_BYTES <= total);
		result.header_ok  = ok;
		result.is_primary = ok && found_d;

		if (word.last_byte) begin
			byte_count_d    = '0;
			header_valid_d  = 1'b0;
			hashed_length_d = '0;
			phase_d         = PH_HEADER;
			area_offset_d   = '0;
			sub_remaining_d = '0;
			len_big_d       = 1'b0;
			length_shift_d  = '0;
			type_matched_d  = 1'b0;
			found_d         = 1'b0;
			stopped_d       = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q    <= '0;
			header_valid_q  <= 1'b0;
			hashed_length_q <= '0;
			phase_q         <= PH_HEADER;
			area_offset_q   <= '0;
			sub_remaining_q <= '0;
			len_big_q       <= 1'b0;
			length_shift_q  <= '0;
			type_matched_q  <= 1'b0;
			found_q         <= 1'b0;
			stopped_q       <= 1'b0;
		end else if (step) begin
			byte_count_q    <= byte_count_d;
			header_valid_q  <= header_valid_d;
			hashed_length_q <= hashed_length_d;
			phase_q         <= phase_d;
			area_offset_q   <= area_offset_d;
			sub_remaining_q <= sub_remaining_d;
			len_big_q       <= len_big_d;
			length_shift_q  <= length_shift_d;
			type_matched_q  <= type_matched_d;
			found_q         <= found_d;
			stopped_q       <= stopped_d;
		end
	end

endmodule

>>> bench/sig_primary_uid_flag_scan_test.sv
`timescale 1ns / 1ps

module sig_primary_uid_flag_scan_test;
	import spuf_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_BYTES = 670;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       given;
		out_word_t  flags;
	} probe_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	in_word_t  item = '0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	out_word_t result;
	logic      result_valid;
	logic      result_ready = 1'b0;

	int send_idle = 35;
	int recv_idle = 87;
	int error_count = 0;
	int cycle_count = 0;

	out_word_t  expected_flags[$];
	logic [7:0] pkt_bytes[$];
	probe_row_t directed_rows[38];

	int unsigned scan_count, scan_hlen, scan_off, scan_left, scan_shift;
	phase_t      scan_phase;
	bit          scan_valid, scan_type_hit, scan_found, scan_stopped;

	sig_primary_uid_flag_scan dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.result      (result),
		.result_valid(result_valid),
		.result_ready(result_ready)
	);

	always #10 clk = ~clk;

	task report_mismatch(input string what, input int got, input int want);
		error_count++;
		$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task clear_scan;
		scan_count    = 0;
		scan_valid    = 0;
		scan_hlen     = 0;
		scan_phase    = PH_HEADER;
		scan_off      = 0;
		scan_left     = 0;
		scan_shift    = 0;
		scan_type_hit = 0;
		scan_found    = 0;
		scan_stopped  = 0;
	endtask

	task check_len(input int unsigned plen);
		if (plen == 0 || plen > scan_hlen - scan_off) begin
			scan_stopped = 1;
		end else begin
			scan_left  = plen;
			scan_phase = PH_TYPE;
		end
	endtask

	task scan_byte(input in_word_t w, output bit done, output out_word_t flags);
		int unsigned v;
		int unsigned total;
		bit ok;
		v = w.data_byte;
		done = 0;
		flags = '0;
		if (scan_phase == PH_HEADER) begin
			case (scan_count)
				POS_VERSION: scan_valid = (v == VERSION_4 || v == VERSION_5);
				POS_SIG_TYPE: scan_valid = scan_valid && v >= SIG_TYPE_MIN && v <= SIG_TYPE_MAX;
				POS_HLEN_HI: scan_hlen = v << 8;
				POS_HLEN_LO: begin
					scan_hlen  = scan_hlen | v;
					scan_phase = PH_LEN1;
				end
				default: ;
			endcase
		end else if (!scan_stopped) begin
			case (scan_phase)
				PH_LEN1: begin
					if (scan_off + 2 >= scan_hlen) begin
						scan_stopped = 1;
					end else begin
						scan_off++;
						if (v < LEN_TWO_BYTE) begin
							check_len(v);
						end else if (v < LEN_FIVE_BYTE) begin
							scan_left  = (v - LEN_TWO_BYTE) << 8;
							scan_phase = PH_LEN2;
						end else if (scan_off + 4 > scan_hlen) begin
							scan_stopped = 1;
						end else begin
							scan_left  = 0;
							scan_shift = 0;
							scan_phase = PH_LEN4;
						end
					end
				end
				PH_LEN2: begin
					scan_off++;
					check_len(scan_left + v + LEN_TWO_BYTE);
				end
				PH_LEN4: begin
					scan_off++;
					scan_left = (scan_left << 8) | v;
					scan_shift++;
					if (scan_shift >= 4) begin
						scan_shift = 0;
						check_len(scan_left);
					end
				end
				PH_TYPE: begin
					scan_off++;
					scan_type_hit = (v & TYPE_MASK) == PRIMARY_UID_TYPE;
					scan_left--;
					if (scan_left == 0)
						scan_phase = PH_LEN1;
					else
						scan_phase = PH_VALUE;
				end
				PH_VALUE: begin
					scan_off++;
					if (scan_type_hit && v != 0) begin
						scan_found   = 1;
						scan_stopped = 1;
					end else begin
						scan_left--;
						if (scan_left == 0)
							scan_phase = PH_LEN1;
						else
							scan_phase = PH_SKIP;
					end
				end
				default: begin
					scan_off++;
					scan_left--;
					if (scan_left == 0)
						scan_phase = PH_LEN1;
				end
			endcase
		end
		total = scan_count + 1;
		if (scan_count < COUNT_MAX)
			scan_count++;
		if (w.last_byte) begin
			ok = total >= HEADER_BYTES && scan_valid && scan_hlen + HEADER_BYTES <= total;
			flags.is_primary = ok && scan_found;
			flags.header_ok  = ok;
			done = 1;
			clear_scan();
		end
	endtask

	task automatic push_byte(input in_word_t w, input logic given, input out_word_t flags);
		bit done;
		out_word_t want;
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		scan_byte(w, done, want);
		if (done)
			expected_flags.push_back(given ? flags : want);
	endtask

	task automatic send_packet;
		for (int i = 0; i < pkt_bytes.size(); i++)
			push_byte({pkt_bytes[i], 1'(i == pkt_bytes.size() - 1)}, 1'b0, 2'b00);
	endtask

	task automatic make_packet;
		int unsigned nsub, vlen, lenf, alen, hlen, cut;
		pkt_bytes.delete();
		if ($urandom_range(99) < 8) begin
			repeat ($urandom_range(12, 1))
				pkt_bytes.push_back(8'($urandom));
		end else begin
			pkt_bytes.push_back(($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(5, 4)));
			pkt_bytes.push_back(($urandom_range(9) == 0) ? 8'($urandom) :
				8'(SIG_TYPE_MIN + $urandom_range(3)));
			pkt_bytes.push_back(8'($urandom));
			pkt_bytes.push_back(8'($urandom));
			pkt_bytes.push_back(8'h00);
			pkt_bytes.push_back(8'h00);
			nsub = $urandom_range(4);
			for (int i = 0; i < nsub; i++) begin
				vlen = ($urandom_range(39) == 0) ? $urandom_range(200, 188) : $urandom_range(3);
				lenf = vlen + 1;
				if ($urandom_range(24) == 0)
					lenf = ($urandom_range(1) == 0) ? 0 : lenf + $urandom_range(300, 1);
				if ($urandom_range(9) == 0) begin
					pkt_bytes.push_back(LEN_FIVE_BYTE);
					pkt_bytes.push_back(8'(lenf >> 24));
					pkt_bytes.push_back(8'(lenf >> 16));
					pkt_bytes.push_back(8'(lenf >> 8));
					pkt_bytes.push_back(8'(lenf));
				end else if (lenf >= LEN_TWO_BYTE) begin
					pkt_bytes.push_back(8'(((lenf - LEN_TWO_BYTE) >> 8) + LEN_TWO_BYTE));
					pkt_bytes.push_back(8'(lenf - LEN_TWO_BYTE));
				end else begin
					pkt_bytes.push_back(8'(lenf));
				end
				case ($urandom_range(2))
					0: pkt_bytes.push_back(PRIMARY_UID_TYPE);
					1: pkt_bytes.push_back(PRIMARY_UID_TYPE | 8'h80);
					default: pkt_bytes.push_back(8'($urandom));
				endcase
				for (int j = 0; j < vlen; j++) begin
					if (j == 0 && $urandom_range(1) == 0)
						pkt_bytes.push_back(8'h00);
					else
						pkt_bytes.push_back(8'($urandom_range(255, 1)));
				end
			end
			if ($urandom_range(5) == 0)
				repeat ($urandom_range(2, 1))
					pkt_bytes.push_back(8'($urandom));
			alen = pkt_bytes.size() - HEADER_BYTES;
			case ($urandom_range(15))
				0: hlen = $urandom_range(16'hFFFF);
				1, 2: hlen = alen + $urandom_range(3);
				3: hlen = (alen > 2) ? alen - $urandom_range(2) : alen;
				default: hlen = alen;
			endcase
			pkt_bytes[POS_HLEN_HI] = 8'(hlen >> 8);
			pkt_bytes[POS_HLEN_LO] = 8'(hlen);
			repeat ($urandom_range(3))
				pkt_bytes.push_back(8'($urandom));
			if ($urandom_range(14) == 0) begin
				cut = $urandom_range(pkt_bytes.size(), 1);
				while (pkt_bytes.size() > cut)
					void'(pkt_bytes.pop_back());
			end
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			if (expected_flags.size() == 0) begin
				report_mismatch("word with no expectation", {result.is_primary, result.header_ok}, -1);
			end else begin
				if (result.is_primary !== expected_flags[0].is_primary)
					report_mismatch("is_primary", result.is_primary, expected_flags[0].is_primary);
				if (result.header_ok !== expected_flags[0].header_ok)
					report_mismatch("header_ok", result.header_ok, expected_flags[0].header_ok);
				void'(expected_flags.pop_front());
			end
		end
		result_ready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		int sent;
		// data, last, given, {is_primary, header_ok}
		directed_rows = '{
			{8'h04, 1'b1, 1'b1, 2'b00},
			{8'h05, 1'b0, 1'b0, 2'b00}, {8'h13, 1'b0, 1'b0, 2'b00},
			{8'hFF, 1'b0, 1'b0, 2'b00}, {8'hFF, 1'b0, 1'b0, 2'b00},
			{8'h00, 1'b0, 1'b0, 2'b00}, {8'h03, 1'b0, 1'b0, 2'b00},
			{8'h02, 1'b0, 1'b0, 2'b00}, {8'h99, 1'b0, 1'b0, 2'b00},
			{8'h01, 1'b1, 1'b1, 2'b11},
			{8'h04, 1'b0, 1'b0, 2'b00}, {8'h10, 1'b0, 1'b0, 2'b00},
			{8'h00, 1'b0, 1'b0, 2'b00}, {8'h00, 1'b0, 1'b0, 2'b00},
			{8'h00, 1'b0, 1'b0, 2'b00}, {8'h01, 1'b1, 1'b1, 2'b00},
			{8'h04, 1'b0, 1'b0, 2'b00}, {8'h12, 1'b0, 1'b0, 2'b00},
			{8'h00, 1'b0, 1'b0, 2'b00}, {8'h00, 1'b0, 1'b0, 2'b00},
			{8'h00, 1'b0, 1'b0, 2'b00}, {8'h07, 1'b0, 1'b0, 2'b00},
			{8'hFF, 1'b0, 1'b0, 2'b00}, {8'h00, 1'b0, 1'b0, 2'b00},
			{8'h00, 1'b0, 1'b0, 2'b00}, {8'h00, 1'b0, 1'b0, 2'b00},
			{8'h02, 1'b0, 1'b0, 2'b00}, {8'h19, 1'b0, 1'b0, 2'b00},
			{8'h00, 1'b1, 1'b0, 2'b00},
			{8'h04, 1'b0, 1'b0, 2'b00}, {8'h11, 1'b0, 1'b0, 2'b00},
			{8'h00, 1'b0, 1'b0, 2'b00}, {8'h00, 1'b0, 1'b0, 2'b00},
			{8'h00, 1'b0, 1'b0, 2'b00}, {8'h03, 1'b0, 1'b0, 2'b00},
			{8'h00, 1'b0, 1'b0, 2'b00}, {8'h19, 1'b0, 1'b0, 2'b00},
			{8'h01, 1'b1, 1'b0, 2'b00}
		};
		clear_scan();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			push_byte({directed_rows[i].data, directed_rows[i].last},
				directed_rows[i].given, directed_rows[i].flags);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 35 : (phase == 1) ? 87 : 0;
			recv_idle = (phase == 0) ? 87 : (phase == 1) ? 35 : 0;
			sent = 0;
			while (sent < PHASE_BYTES) begin
				make_packet();
				send_packet();
				sent += pkt_bytes.size();
			end
		end
		item_valid <= 1'b0;

		while (expected_flags.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
